FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// implication checked in the following cycle
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

FILE: rtl/iiee_pkg.sv
// shared types and constants of the expression evaluator
`default_nettype none
package iiee_pkg;
  localparam logic [2:0] OP_OPEN = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_NEG  = 3'd5;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_DIV0  = 2'd1;
  localparam logic [1:0] ERR_PAREN = 2'd2;
  localparam logic [1:0] ERR_OVF   = 2'd3;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_MUL   = 8'h2a;
  localparam logic [7:0] CH_ADD   = 8'h2b;
  localparam logic [7:0] CH_SUB   = 8'h2d;
  localparam logic [7:0] CH_DIV   = 8'h2f;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // commands from controller to datapath
  typedef struct packed {
    logic       clear;        // back to reset state
    logic       acc_digit;    // accumulate digit from ch
    logic       set_unary;    // load unary_allowed
    logic       unary_val;
    logic       close_num;    // push pending number
    logic       push_op;      // push op_code
    logic [2:0] op_code;
    logic       pop_op;       // drop top operator
    logic       pop_b;        // pop operand into b
    logic       pop_a;        // pop operand into a
    logic       start_alu;    // start op in alu on a,b
    logic       push_res;     // push alu result
    logic       pop_out;      // pop operand into output
    logic       set_err;
    logic [1:0] err_code;
  } iiee_cmd_t;

  typedef struct packed {
    logic       op_empty;
    logic [2:0] op_top;
    logic       alu_busy;
    logic [1:0] error;
    logic       unary_allowed;
  } iiee_stat_t;

  function automatic logic [2:0] rank(input logic [2:0] op);
    case (op)
      OP_ADD, OP_SUB: rank = 3'd2;
      OP_MUL, OP_DIV: rank = 3'd3;
      OP_NEG:         rank = 3'd5;
      default:        rank = 3'd0;
    endcase
  endfunction
endpackage
`default_nettype wire

FILE: rtl/iiee_alu.sv
// arithmetic unit: add, subtract, negate, multiply, radix-2 divide
`default_nettype none
module iiee_alu (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [2:0]  op,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic             busy,
  output logic             div0,
  output logic [31:0]      result
);
  logic [31:0] rem, quo, divisor;
  logic [5:0]  cnt;
  logic        neg_q, div_run;
  logic [32:0] diff;
  logic [31:0] rem_sh;

  assign rem_sh = {rem[30:0], quo[31]};
  assign diff = {1'b0, rem_sh} - {1'b0, divisor};
  assign busy = div_run;

  always_ff @(posedge clk) begin
    div0 <= !rst && start && (op == iiee_pkg::OP_DIV) && (b == 32'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_run <= 1'b0;
    end else if (start) begin
      case (op)
        iiee_pkg::OP_ADD: result <= a + b;
        iiee_pkg::OP_SUB: result <= a - b;
        iiee_pkg::OP_MUL: result <= a * b;
        iiee_pkg::OP_NEG: result <= 32'd0 - b;
        iiee_pkg::OP_DIV: begin
          if (b == 32'd0) begin
            result <= 32'd0;
          end else begin
            div_run <= 1'b1;
            cnt <= 6'd32;
            rem <= 32'd0;
            quo <= a[31] ? 32'd0 - a : a;
            divisor <= b[31] ? 32'd0 - b : b;
            neg_q <= a[31] ^ b[31];
          end
        end
        default: result <= 32'd0;
      endcase
    end else if (div_run) begin
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[30:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        div_run <= 1'b0;
        result <= neg_q ? 32'd0 - {quo[30:0], ~diff[32]} : {quo[30:0], ~diff[32]};
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/iiee_datapath.sv
// stacks, number accumulator and operand registers
`default_nettype none
`include "assert_macros.svh"
module iiee_datapath #(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [7:0]    ch,
  input  wire iiee_pkg::iiee_cmd_t cmd,
  output iiee_pkg::iiee_stat_t     stat,
  output logic [31:0]        out_value
);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [31:0] opnd_mem [STACK_DEPTH];
  logic [2:0]  oper_mem [STACK_DEPTH];
  logic [CW-1:0] opnd_cnt, oper_cnt;
  logic [31:0] acc, a_reg, b_reg;
  logic        pending, unary, alu_busy, div0;
  logic [1:0]  err;
  logic [31:0] alu_res, top_val;
  logic [2:0]  top_op;
  logic [CW-1:0] opnd_idx, oper_idx;
  logic        opnd_full, oper_full, do_push_val;
  logic [31:0] push_data;

  assign opnd_idx = opnd_cnt - CW'(1);
  assign oper_idx = oper_cnt - CW'(1);
  assign top_val = (opnd_cnt == '0) ? 32'd0 : opnd_mem[opnd_idx[AW-1:0]];
  assign top_op  = oper_mem[oper_idx[AW-1:0]];
  assign opnd_full = (opnd_cnt == CW'(STACK_DEPTH));
  assign oper_full = (oper_cnt == CW'(STACK_DEPTH));
  assign do_push_val = (cmd.close_num && pending) || cmd.push_res;
  assign push_data = cmd.push_res ? alu_res : acc;

  iiee_alu u_alu (
    .clk(clk), .rst(rst), .start(cmd.start_alu), .op(top_op),
    .a(a_reg), .b(b_reg), .busy(alu_busy), .div0(div0), .result(alu_res)
  );

  always_ff @(posedge clk) begin
    if (do_push_val && !opnd_full) opnd_mem[opnd_cnt[AW-1:0]] <= push_data;
    if (cmd.push_op && !oper_full) oper_mem[oper_cnt[AW-1:0]] <= cmd.op_code;
    // a number closed in the same cycle goes straight to b
    if (cmd.pop_b) b_reg <= (cmd.close_num && pending && !opnd_full) ? acc : top_val;
    if (cmd.pop_a) a_reg <= top_val;
    if (cmd.pop_out) out_value <= top_val;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      opnd_cnt <= '0;
      oper_cnt <= '0;
      acc <= 32'd0;
      pending <= 1'b0;
      unary <= 1'b1;
      err <= iiee_pkg::ERR_NONE;
    end else begin
      if (cmd.acc_digit) begin
        acc <= acc * 32'd10 + {24'd0, ch - iiee_pkg::CH_ZERO};
        pending <= 1'b1;
      end
      if (cmd.close_num && pending) begin
        acc <= 32'd0;
        pending <= 1'b0;
      end
      if (cmd.set_unary) unary <= cmd.unary_val;
      if (do_push_val && !opnd_full) begin
        if (!cmd.pop_b) opnd_cnt <= opnd_cnt + CW'(1);
      end else if (cmd.pop_a || cmd.pop_b || cmd.pop_out) begin
        if (opnd_cnt != '0) opnd_cnt <= opnd_cnt - CW'(1);
      end
      if (cmd.push_op && !oper_full) begin
        oper_cnt <= oper_cnt + CW'(1);
      end else if (cmd.pop_op) begin
        oper_cnt <= oper_cnt - CW'(1);
      end
      if (err == iiee_pkg::ERR_NONE) begin
        if ((do_push_val && opnd_full) || (cmd.push_op && oper_full)) begin
          err <= iiee_pkg::ERR_OVF;
        end else if (div0) begin
          err <= iiee_pkg::ERR_DIV0;
        end else if (cmd.set_err) begin
          err <= cmd.err_code;
        end
      end
    end
  end

  assign stat.op_empty = (oper_cnt == '0);
  assign stat.op_top = top_op;
  assign stat.alu_busy = alu_busy;
  assign stat.error = err;
  assign stat.unary_allowed = unary;

  `ASSERT_IMPL(a_opnd_bound, clk, rst, 1'b1, opnd_cnt <= CW'(STACK_DEPTH))
  `ASSERT_IMPL(a_oper_bound, clk, rst, 1'b1, oper_cnt <= CW'(STACK_DEPTH))
  `ASSERT_NEXT(a_err_sticky, clk, rst,
    err != iiee_pkg::ERR_NONE && !cmd.clear, err == $past(err))
endmodule
`default_nettype wire

FILE: rtl/iiee_ctrl.sv
// controller state machine sequencing reductions
`default_nettype none
`include "assert_macros.svh"
module iiee_ctrl (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_fire,
  input  wire logic [7:0] ch,
  input  wire logic       last,
  input  wire logic       out_taken,
  input  wire iiee_pkg::iiee_stat_t stat,
  output iiee_pkg::iiee_cmd_t       cmd,
  output logic            in_ready,
  output logic            out_valid
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_RED   = 8'b00000010,
    S_POPA  = 8'b00000100,
    S_ALU   = 8'b00001000,
    S_WAIT  = 8'b00010000,
    S_PUSH  = 8'b00100000,
    S_DONE  = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  typedef enum logic [1:0] {
    M_BIN = 2'd0, M_PAREN = 2'd1, M_FIN = 2'd2
  } mode_t;

  state_t state, state_next;
  mode_t  mode;
  logic [2:0] pend_op;
  logic       fin, neg_op;
  logic       is_digit, ok;
  logic       loop_go;

  assign is_digit = (ch >= iiee_pkg::CH_ZERO) && (ch <= iiee_pkg::CH_NINE);
  assign ok = (stat.error == iiee_pkg::ERR_NONE);
  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign neg_op = (stat.op_top == iiee_pkg::OP_NEG);

  always_comb begin
    loop_go = 1'b0;
    case (mode)
      M_BIN:   loop_go = !stat.op_empty &&
                 (iiee_pkg::rank(stat.op_top) >= iiee_pkg::rank(pend_op));
      M_PAREN: loop_go = !stat.op_empty && stat.op_top != iiee_pkg::OP_OPEN;
      default: loop_go = ok && !stat.op_empty && stat.op_top != iiee_pkg::OP_OPEN;
    endcase
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (ok) begin
            cmd.set_unary = 1'b1;
            cmd.unary_val = (ch == iiee_pkg::CH_OPEN);
            if (ch == iiee_pkg::CH_OPEN) begin
              cmd.push_op = 1'b1;
              cmd.op_code = iiee_pkg::OP_OPEN;
            end else if (is_digit) begin
              cmd.acc_digit = 1'b1;
            end else if (ch == iiee_pkg::CH_SUB && stat.unary_allowed) begin
              cmd.push_op = 1'b1;
              cmd.op_code = iiee_pkg::OP_NEG;
            end else if (ch == iiee_pkg::CH_ADD || ch == iiee_pkg::CH_SUB ||
                         ch == iiee_pkg::CH_MUL || ch == iiee_pkg::CH_DIV) begin
              cmd.close_num = 1'b1;
            end
          end
          state_next = S_RED;
        end
      end
      S_RED: begin
        if (!ok) begin
          state_next = fin ? S_DONE : S_IDLE;
        end else if (mode == M_BIN && pend_op == iiee_pkg::OP_OPEN) begin
          state_next = fin ? S_RED : S_IDLE;
        end else if (loop_go) begin
          cmd.close_num = 1'b1;
          cmd.pop_b = 1'b1;
          state_next = neg_op ? S_ALU : S_POPA;
        end else begin
          state_next = fin ? S_RED : S_IDLE;
          case (mode)
            M_BIN: begin
              cmd.push_op = 1'b1;
              cmd.op_code = pend_op;
            end
            M_PAREN: begin
              if (stat.op_empty) begin
                cmd.set_err = 1'b1;
                cmd.err_code = iiee_pkg::ERR_PAREN;
              end else begin
                cmd.pop_op = 1'b1;
              end
            end
            default: begin
              cmd.close_num = 1'b1;
              if (!stat.op_empty) begin
                cmd.set_err = 1'b1;
                cmd.err_code = iiee_pkg::ERR_PAREN;
              end
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_POPA: begin
        cmd.pop_a = 1'b1;
        state_next = S_ALU;
      end
      S_ALU: begin
        cmd.start_alu = 1'b1;
        cmd.pop_op = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (!stat.alu_busy) state_next = S_PUSH;
      end
      S_PUSH: begin
        cmd.push_res = 1'b1;
        state_next = S_RED;
      end
      S_DONE: begin
        cmd.pop_out = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_taken) begin
          cmd.clear = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register, final-character flag and mode of the reduction that follows an accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode <= M_BIN;
      pend_op <= iiee_pkg::OP_OPEN;
      fin <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        fin <= last;
        if (ok && !(ch == iiee_pkg::CH_SUB && stat.unary_allowed)) begin
          case (ch)
            iiee_pkg::CH_ADD: begin
              mode <= M_BIN;
              pend_op <= iiee_pkg::OP_ADD;
            end
            iiee_pkg::CH_SUB: begin
              mode <= M_BIN;
              pend_op <= iiee_pkg::OP_SUB;
            end
            iiee_pkg::CH_MUL: begin
              mode <= M_BIN;
              pend_op <= iiee_pkg::OP_MUL;
            end
            iiee_pkg::CH_DIV: begin
              mode <= M_BIN;
              pend_op <= iiee_pkg::OP_DIV;
            end
            iiee_pkg::CH_CLOSE: begin
              mode <= M_PAREN;
              pend_op <= iiee_pkg::OP_OPEN;
            end
            default: begin
              mode <= M_BIN;
              pend_op <= iiee_pkg::OP_OPEN;
            end
          endcase
        end else begin
          mode <= M_BIN;
          pend_op <= iiee_pkg::OP_OPEN;
        end
      end else if (state == S_RED && state_next == S_RED) begin
        mode <= M_FIN;
      end
    end
  end

  `ASSERT_IMPL(a_ready_idle, clk, rst, in_ready, !out_valid)
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_taken, out_valid)
  `ASSERT_IMPL(a_state_onehot, clk, rst, 1'b1, $onehot(state))
endmodule
`default_nettype wire

FILE: rtl/infix_integer_expression_evaluator_core.sv
// Infix integer expression evaluator, top level.
// Input channel s_axis: one ASCII character per word in tdata, tlast marks
// the final character of an expression. Output channel m_axis: one word per
// expression, sent after its final character: value in tdata[31:0] and the
// error code in tdata[33:32] (0 ok, 1 divide by zero, 2 unbalanced
// parentheses, 3 stack overflow); value is 0 on error.
// Each character is taken in the idle state and then reduced: per operator,
// the controller pops b, then a (not for negate), starts the shared alu
// (one quotient bit per cycle for a divide), waits and pushes the result.
// Last, the final reductions, an end check and a result pop precede m_axis_tvalid.
// Characters are taken one at a time; s_axis_tready is low while a word is
// processed and while a result waits. If the receiver stalls, the result
// holds in m_axis_tdata and no new character is taken until it is taken.
// Reset (rst, synchronous) empties both stacks and clears the number,
// error code and any pending result; no clearing pass is needed.
// After a result is taken the stacks, number and error code return to the reset condition.
`default_nettype none
module infix_integer_expression_evaluator_core #(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // ch[7:0]
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata   // value[31:0], error[33:32], zero fill
);
  iiee_pkg::iiee_cmd_t  cmd;
  iiee_pkg::iiee_stat_t stat;
  logic [31:0] value;
  logic in_fire;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  iiee_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .ch(s_axis_tdata),
    .last(s_axis_tlast), .out_taken(m_axis_tvalid && m_axis_tready),
    .stat(stat), .cmd(cmd), .in_ready(s_axis_tready), .out_valid(m_axis_tvalid)
  );

  iiee_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .ch(s_axis_tdata), .cmd(cmd), .stat(stat),
    .out_value(value)
  );

  assign m_axis_tdata = {6'd0, stat.error,
                         (stat.error == iiee_pkg::ERR_NONE) ? value : 32'd0};
endmodule
`default_nettype wire
